### rtl/core/bbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Butterfly counter package
// Types, codes and constants shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int VERTEX_W         = 6;
    localparam int VERTEX_COUNT_W   = 7;
    localparam int WEDGE_W          = 17;
    localparam int BFLY_W           = 22;

    localparam logic [VERTEX_COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;
    localparam logic [WEDGE_W-1:0]        WEDGE_MAX          = '1;
    localparam logic [BFLY_W-1:0]         BFLY_MAX           = '1;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_COUNT = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_STORED = 3'd0,
        ST_RANGE  = 3'd1,
        ST_SELF   = 3'd2,
        ST_DUP    = 3'd3,
        ST_DONE   = 3'd4
    } status_code_t;

    typedef struct packed {
        logic         load_in;
        logic         rd_edge;
        logic         wr_a;
        logic         wr_b;
        logic         clr_graph;
        logic         pair_start;
        logic         pair_issue;
        logic         acc_clear;
        logic         res_load;
        logic         res_totals;
        status_code_t res_status;
    } bbc_cmd_t;

    typedef struct packed {
        func_t func;
        logic  bad_range;
        logic  self_loop;
        logic  dup;
        logic  last_pair;
        logic  no_pairs;
        logic  pipe_empty;
        logic  out_busy;
    } bbc_stat_t;

endpackage

### rtl/core/bbc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Butterfly counter controller
// Sequences edge insertion, pair counting, clearing and the result transfer.
// ----------------------------------------------------------------------------
module bbc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bbc_pkg::bbc_stat_t st,
    output bbc_pkg::bbc_cmd_t  cmd
);
    import bbc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_EDGE_CHK,
        S_EDGE_WB,
        S_COUNT,
        S_DRAIN,
        S_RESP
    } state_t;

    state_t       state_reg, state_next;
    status_code_t code_reg, code_next;
    logic         totals_reg, totals_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            code_reg   <= ST_DONE;
            totals_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            code_reg   <= code_next;
            totals_reg <= totals_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        code_next      = code_reg;
        totals_next    = totals_reg;
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.res_status = code_reg;
        cmd.res_totals = totals_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    totals_next = 1'b0;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                case (st.func)
                    FUNC_ADD: begin
                        if (st.bad_range) begin
                            code_next  = ST_RANGE;
                            state_next = S_RESP;
                        end else if (st.self_loop) begin
                            code_next  = ST_SELF;
                            state_next = S_RESP;
                        end else begin
                            cmd.rd_edge = 1'b1;
                            state_next  = S_EDGE_CHK;
                        end
                    end
                    FUNC_COUNT: begin
                        cmd.acc_clear  = 1'b1;
                        cmd.pair_start = 1'b1;
                        totals_next    = 1'b1;
                        code_next      = ST_DONE;
                        state_next     = st.no_pairs ? S_RESP : S_COUNT;
                    end
                    FUNC_CLEAR: begin
                        cmd.clr_graph = 1'b1;
                        code_next     = ST_DONE;
                        state_next    = S_RESP;
                    end
                    default: begin
                        code_next  = ST_DONE;
                        state_next = S_RESP;
                    end
                endcase
            end
            S_EDGE_CHK: begin
                if (st.dup) begin
                    code_next  = ST_DUP;
                    state_next = S_RESP;
                end else begin
                    cmd.wr_a   = 1'b1;
                    state_next = S_EDGE_WB;
                end
            end
            S_EDGE_WB: begin
                cmd.wr_b   = 1'b1;
                code_next  = ST_STORED;
                state_next = S_RESP;
            end
            S_COUNT: begin
                cmd.pair_issue = 1'b1;
                if (st.last_pair) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (st.pipe_empty) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (!st.out_busy) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/bbc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Butterfly counter datapath
// Adjacency memory, pair counters, common neighbour pipeline and totals.
// ----------------------------------------------------------------------------
module bbc_datapath #(
    parameter int MAX_VERTICES = bbc_pkg::MAX_VERTICES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bbc_pkg::VERTEX_COUNT_W-1:0] cfg_wr_data,
    input  logic [1:0]                         s_func,
    input  logic [bbc_pkg::VERTEX_W-1:0]       s_first_vertex,
    input  logic [bbc_pkg::VERTEX_W-1:0]       s_second_vertex,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [2:0]                         m_status,
    output logic [bbc_pkg::WEDGE_W-1:0]        m_wedge_total,
    output logic [bbc_pkg::BFLY_W-1:0]         m_butterfly_total,
    input  bbc_pkg::bbc_cmd_t                  cmd,
    output bbc_pkg::bbc_stat_t                 st
);
    import bbc_pkg::*;

    localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW    = $clog2(MAX_VERTICES + 1);
    localparam int XW    = (NW > VERTEX_COUNT_W) ? NW : VERTEX_COUNT_W;
    localparam int CHB   = 8;
    localparam int NCH   = (MAX_VERTICES + CHB - 1) / CHB;
    localparam int GRP   = 8;
    localparam int NGR   = (NCH + GRP - 1) / GRP;
    localparam int NCHP  = NGR * GRP;
    localparam int PADW  = NCHP * CHB;
    localparam int CHW   = 4;
    localparam int GW    = 7;
    localparam int CSW   = NW + GW;
    localparam int TW    = 2 * NW - 1;
    localparam int WSW   = ((NW > WEDGE_W) ? NW : WEDGE_W) + 1;
    localparam int BSW   = ((TW > BFLY_W) ? TW : BFLY_W) + 1;

    // Configuration and the captured command.
    logic [VERTEX_COUNT_W-1:0] vcount_reg;
    logic [1:0]                func_reg;
    logic [VERTEX_W-1:0]       a_raw_reg, b_raw_reg;

    logic [NW-1:0] n_eff;
    logic [XW-1:0] a_ext, b_ext;
    logic [AW-1:0] a_addr, b_addr;

    // Adjacency memory and per-row valid bits.
    logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] row_vld_reg;
    logic [MAX_VERTICES-1:0] rd1_reg, rd2_reg;
    logic                    rv1_reg, rv2_reg;
    logic [MAX_VERTICES-1:0] row1, row2;
    logic [MAX_VERTICES-1:0] onehot_a, onehot_b;
    logic [MAX_VERTICES-1:0] wdata;
    logic [AW-1:0]           waddr, raddr1, raddr2;
    logic                    we, rd_en;

    // Pair walk.
    logic [AW-1:0] u1_reg, u2_reg;
    logic          row_end;

    // Counting pipeline.
    logic [MAX_VERTICES-1:0] mask_reg, mask_vec;
    logic [PADW-1:0]         and_pad;
    logic [CHW-1:0]          chunk_cnt [NCHP];
    logic [CHW-1:0]          ch_reg    [NCHP];
    logic [GW-1:0]           grp_sum   [NGR];
    logic [GW-1:0]           grp_reg   [NGR];
    logic [CSW-1:0]          c_sum;
    logic [NW-1:0]           c_reg, ct_reg;
    logic [2*NW-1:0]         prod;
    logic [TW-1:0]           term_reg;
    logic                    v_rd_reg, v_ch_reg, v_gr_reg, v_c_reg, v_t_reg;

    logic [WEDGE_W-1:0] wedge_acc_reg;
    logic [BFLY_W-1:0]  bfly_acc_reg;
    logic [WSW-1:0]     wedge_sum;
    logic [BSW-1:0]     bfly_sum;

    logic                 m_valid_reg;
    logic [2:0]           m_status_reg;
    logic [WEDGE_W-1:0]   m_wedge_reg;
    logic [BFLY_W-1:0]    m_bfly_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= VERTEX_COUNT_RESET;
        end else if (cfg_wr_en) begin
            vcount_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg  <= s_func;
            a_raw_reg <= s_first_vertex;
            b_raw_reg <= s_second_vertex;
        end
    end

    assign n_eff  = (XW'(vcount_reg) > XW'(MAX_VERTICES)) ? NW'(MAX_VERTICES)
                                                          : NW'(vcount_reg);
    assign a_ext  = XW'(a_raw_reg);
    assign b_ext  = XW'(b_raw_reg);
    assign a_addr = a_ext[AW-1:0];
    assign b_addr = b_ext[AW-1:0];

    assign row1 = rv1_reg ? rd1_reg : '0;
    assign row2 = rv2_reg ? rd2_reg : '0;

    always_comb begin
        onehot_a         = '0;
        onehot_b         = '0;
        onehot_a[a_addr] = 1'b1;
        onehot_b[b_addr] = 1'b1;
    end

    assign we     = cmd.wr_a | cmd.wr_b;
    assign waddr  = cmd.wr_a ? a_addr : b_addr;
    assign wdata  = cmd.wr_a ? (row1 | onehot_b) : (row2 | onehot_a);
    assign rd_en  = cmd.rd_edge | cmd.pair_issue;
    assign raddr1 = cmd.rd_edge ? a_addr : u1_reg;
    assign raddr2 = cmd.rd_edge ? b_addr : u2_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            adj_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd1_reg <= adj_mem[raddr1];
            rd2_reg <= adj_mem[raddr2];
            rv1_reg <= row_vld_reg[raddr1];
            rv2_reg <= row_vld_reg[raddr2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
        end else if (cmd.clr_graph) begin
            row_vld_reg <= '0;
        end else if (we) begin
            row_vld_reg[waddr] <= 1'b1;
        end
    end

    assign row_end = ((NW + 1)'(u2_reg) + (NW + 1)'(1)) == (NW + 1)'(n_eff);

    always_ff @(posedge aclk) begin
        if (cmd.pair_start) begin
            u1_reg <= '0;
            u2_reg <= AW'(1);
        end else if (cmd.pair_issue) begin
            if (row_end) begin
                u1_reg <= u1_reg + AW'(1);
                u2_reg <= u1_reg + AW'(2);
            end else begin
                u2_reg <= u2_reg + AW'(1);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            mask_vec[i] = NW'(i) < n_eff;
        end
    end

    always_ff @(posedge aclk) begin
        mask_reg <= mask_vec;
    end

    assign and_pad = PADW'(row1 & row2 & mask_reg);

    always_comb begin
        for (int k = 0; k < NCHP; k++) begin
            chunk_cnt[k] = '0;
            for (int j = 0; j < CHB; j++) begin
                chunk_cnt[k] = chunk_cnt[k] + CHW'(and_pad[k*CHB+j]);
            end
        end
    end

    always_comb begin
        for (int g = 0; g < NGR; g++) begin
            grp_sum[g] = '0;
            for (int j = 0; j < GRP; j++) begin
                grp_sum[g] = grp_sum[g] + GW'(ch_reg[g*GRP+j]);
            end
        end
    end

    always_comb begin
        c_sum = '0;
        for (int g = 0; g < NGR; g++) begin
            c_sum = c_sum + CSW'(grp_reg[g]);
        end
    end

    assign prod = (2 * NW)'(c_reg) * (2 * NW)'(c_reg - NW'(1));

    always_ff @(posedge aclk) begin
        ch_reg   <= chunk_cnt;
        grp_reg  <= grp_sum;
        c_reg    <= NW'(c_sum);
        ct_reg   <= c_reg;
        term_reg <= prod[2*NW-1:1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_rd_reg <= 1'b0;
            v_ch_reg <= 1'b0;
            v_gr_reg <= 1'b0;
            v_c_reg  <= 1'b0;
            v_t_reg  <= 1'b0;
        end else begin
            v_rd_reg <= cmd.pair_issue;
            v_ch_reg <= v_rd_reg;
            v_gr_reg <= v_ch_reg;
            v_c_reg  <= v_gr_reg;
            v_t_reg  <= v_c_reg;
        end
    end

    assign wedge_sum = WSW'(wedge_acc_reg) + WSW'(ct_reg);
    assign bfly_sum  = BSW'(bfly_acc_reg) + BSW'(term_reg);

    always_ff @(posedge aclk) begin
        if (cmd.acc_clear) begin
            wedge_acc_reg <= '0;
            bfly_acc_reg  <= '0;
        end else if (v_t_reg) begin
            wedge_acc_reg <= (wedge_sum > WSW'(WEDGE_MAX)) ? WEDGE_MAX
                                                           : wedge_sum[WEDGE_W-1:0];
            bfly_acc_reg  <= (bfly_sum > BSW'(BFLY_MAX)) ? BFLY_MAX
                                                         : bfly_sum[BFLY_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            m_status_reg <= cmd.res_status;
            m_wedge_reg  <= cmd.res_totals ? wedge_acc_reg : '0;
            m_bfly_reg   <= cmd.res_totals ? bfly_acc_reg : '0;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_wedge_total     = m_wedge_reg;
    assign m_butterfly_total = m_bfly_reg;

    always_comb begin
        st            = '0;
        st.func       = func_t'(func_reg);
        st.bad_range  = (a_ext >= XW'(n_eff)) || (b_ext >= XW'(n_eff));
        st.self_loop  = a_raw_reg == b_raw_reg;
        st.dup        = row1[b_addr];
        st.last_pair  = (((NW + 1)'(u1_reg) + (NW + 1)'(2)) == (NW + 1)'(n_eff)) && row_end;
        st.no_pairs   = n_eff < NW'(2);
        st.pipe_empty = !(v_rd_reg || v_ch_reg || v_gr_reg || v_c_reg || v_t_reg);
        st.out_busy   = m_valid_reg && !m_ready;
    end

endmodule

### rtl/core/bipartite_butterfly_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bipartite butterfly counter
// Holds a simple undirected graph as an adjacency bit matrix and counts the
// wedges and butterflies over all vertex pairs on command.
// ----------------------------------------------------------------------------
//  Channel   Ports                                         Direction
//  s_        s_func, s_first_vertex, s_second_vertex        in,  valid/ready
//  m_        m_status, m_wedge_total, m_butterfly_total     out, valid/ready
//  cfg_      cfg_wr_en, cfg_wr_data (vertex_count)          in,  write only
//
// A stored edge passes execute, edge check, edge write-back and response; a
// duplicate goes from edge check to response, and a rejected edge, a clear or an
// unused command from execute to response. A count walks all n*(n-1)/2 pairs,
// n being the vertices in use, when n is two or more, as the two read ports of
// the adjacency memory fetch one vertex pair per cycle; else it skips the walk.
// Reset clears the row valid bits at once, so no clearing pass follows it.
// One new item may be taken while a result waits; it is held until m_ready.
// ----------------------------------------------------------------------------
module bipartite_butterfly_counter #(
    parameter int MAX_VERTICES = bbc_pkg::MAX_VERTICES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bbc_pkg::VERTEX_COUNT_W-1:0] cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_func,
    input  logic [bbc_pkg::VERTEX_W-1:0]       s_first_vertex,
    input  logic [bbc_pkg::VERTEX_W-1:0]       s_second_vertex,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [2:0]                         m_status,
    output logic [bbc_pkg::WEDGE_W-1:0]        m_wedge_total,
    output logic [bbc_pkg::BFLY_W-1:0]         m_butterfly_total
);
    import bbc_pkg::*;

    bbc_cmd_t  cmd;
    bbc_stat_t st;

    bbc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    bbc_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_func            (s_func),
        .s_first_vertex    (s_first_vertex),
        .s_second_vertex   (s_second_vertex),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_wedge_total     (m_wedge_total),
        .m_butterfly_total (m_butterfly_total),
        .cmd               (cmd),
        .st                (st)
    );

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("Input taken while an item is still in progress.");

    a_totals_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_DONE) |-> (m_wedge_total == '0 && m_butterfly_total == '0))
        else $error("Totals are non-zero on an edge result.");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= ST_DONE))
        else $error("Result status code out of range.");

    a_bfly_needs_wedge: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_butterfly_total != '0) |-> (m_wedge_total != '0))
        else $error("Butterflies reported without wedges.");

endmodule
